// File: hdl/tmhs_pkg.sv
// ----------------------------------------------------------------------------
// tmhs_pkg
// shared types and constants for the timer min-heap scheduler
// ----------------------------------------------------------------------------
package tmhs_pkg;

    localparam int unsigned HEAP_DEPTH_DEF = 1024;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned TICK_W   = 32;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 11;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_POP    = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_DUE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // datapath commands
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_START     = 4'd1;  // latch word, clear search position
    localparam logic [3:0] CMD_INS_BEGIN = 4'd2;  // hole at tail, count up, moved = new entry
    localparam logic [3:0] CMD_RD_POS    = 4'd3;  // read entry at search position
    localparam logic [3:0] CMD_RD_PARENT = 4'd4;  // read parent of hole
    localparam logic [3:0] CMD_RD_KIDS   = 4'd5;  // read both children of hole
    localparam logic [3:0] CMD_POS_INC   = 4'd6;
    localparam logic [3:0] CMD_TAKE_LAST = 4'd7;  // read tail, count down, hole = position
    localparam logic [3:0] CMD_LATCH_MV  = 4'd8;  // moved entry = tail entry
    localparam logic [3:0] CMD_UP_MOVE   = 4'd9;  // parent into hole, hole = parent
    localparam logic [3:0] CMD_DN_MOVE   = 4'd10; // smaller child into hole, hole = child
    localparam logic [3:0] CMD_WR_MOVED  = 4'd11; // moved entry into hole

    typedef struct packed {
        logic [3:0] cmd;
        logic [STATUS_W-1:0] status;
    } t_ctrl;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic empty;
        logic full;
        logic hole_zero;
        logic hole_is_last;
        logic par_gt;      // parent deadline above moved deadline
        logic srch_end;    // search ran past last entry
        logic srch_hit;    // current search entry matches handle
        logic root_due;
        logic no_kid;
        logic dn_stop;
    } t_stat;

endpackage

// File: hdl/tmhs_datapath.sv
// ----------------------------------------------------------------------------
// tmhs_datapath
// heap memory, item registers, address walk and compares
// ----------------------------------------------------------------------------
module tmhs_datapath #(
    parameter int unsigned HEAP_DEPTH = tmhs_pkg::HEAP_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tmhs_pkg::t_ctrl                    i_ctrl,
    input  logic [tmhs_pkg::OP_W-1:0]          i_op,
    input  logic [tmhs_pkg::HANDLE_W-1:0]      i_handle,
    input  logic [tmhs_pkg::TICK_W-1:0]        i_deadline,
    input  logic [tmhs_pkg::TICK_W-1:0]        i_time_now,
    output tmhs_pkg::t_stat                    o_stat,
    output logic [tmhs_pkg::HANDLE_W-1:0]      o_fired_handle,
    output logic [tmhs_pkg::TICK_W-1:0]        o_fired_deadline,
    output logic [tmhs_pkg::COUNT_W-1:0]       o_entry_count
);
    localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int unsigned PW = AW + 2;
    localparam int unsigned EW = tmhs_pkg::HANDLE_W + tmhs_pkg::TICK_W;
    localparam int unsigned HW = tmhs_pkg::HANDLE_W;
    localparam int unsigned TW = tmhs_pkg::TICK_W;
    localparam int unsigned CW = tmhs_pkg::COUNT_W;

    logic [EW-1:0] r_mem [HEAP_DEPTH];
    logic [EW-1:0] r_ra, r_rb;

    logic [AW:0]   r_fill;
    logic [PW-1:0] r_pos, r_hole;
    logic [HW-1:0] r_h, r_mv_h;
    logic [TW-1:0] r_d, r_mv_d, r_now;
    logic [tmhs_pkg::OP_W-1:0] r_op;
    logic [HW-1:0] r_fh;
    logic [TW-1:0] r_fd;

    logic [PW-1:0] w_fill, w_last;
    logic [PW-1:0] w_parent, w_child, w_child2;
    logic [TW-1:0] w_da, w_db;
    logic          w_right;
    logic [TW-1:0] w_cd;
    logic [PW-1:0] w_ci;

    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [EW-1:0] w_wd;
    logic          w_rea, w_reb;
    logic [AW-1:0] w_aa, w_ab;

    assign w_fill   = PW'(r_fill);
    assign w_last   = w_fill - {{(PW-1){1'b0}}, 1'b1};
    assign w_parent = (r_hole - {{(PW-1){1'b0}}, 1'b1}) >> 1;
    assign w_child  = {r_hole[PW-2:0], 1'b1};
    assign w_child2 = w_child + {{(PW-1){1'b0}}, 1'b1};
    assign w_da     = r_ra[TW-1:0];
    assign w_db     = r_rb[TW-1:0];
    // right child wins only if present and strictly smaller
    assign w_right  = (w_child < w_last) && (w_da > w_db);
    assign w_cd     = w_right ? w_db : w_da;
    assign w_ci     = w_right ? w_child2 : w_child;

    always_comb begin
        o_stat.op           = r_op;
        o_stat.empty        = (r_fill == '0);
        o_stat.full         = (r_fill >= (AW+1)'(HEAP_DEPTH));
        o_stat.hole_zero    = (r_hole == '0);
        o_stat.hole_is_last = (r_hole == w_fill);
        o_stat.par_gt       = (w_da > r_mv_d);
        o_stat.srch_end     = (r_pos >= w_fill);
        o_stat.srch_hit     = (r_ra[EW-1:TW] == r_h);
        o_stat.root_due     = (w_da <= r_now);
        o_stat.no_kid       = (w_child >= w_fill);
        o_stat.dn_stop      = (r_mv_d <= w_cd);
    end

    // memory port control
    always_comb begin
        w_we = 1'b0; w_wa = r_hole[AW-1:0]; w_wd = {r_mv_h, r_mv_d};
        w_rea = 1'b0; w_reb = 1'b0;
        w_aa = r_pos[AW-1:0]; w_ab = w_child2[AW-1:0];
        case (i_ctrl.cmd)
            tmhs_pkg::CMD_RD_POS: begin
                w_rea = 1'b1; w_aa = r_pos[AW-1:0];
            end
            tmhs_pkg::CMD_RD_PARENT: begin
                w_rea = 1'b1; w_aa = w_parent[AW-1:0];
            end
            tmhs_pkg::CMD_RD_KIDS: begin
                w_rea = 1'b1; w_reb = 1'b1;
                w_aa = w_child[AW-1:0]; w_ab = w_child2[AW-1:0];
            end
            tmhs_pkg::CMD_TAKE_LAST: begin
                w_rea = 1'b1; w_aa = w_last[AW-1:0];
            end
            tmhs_pkg::CMD_UP_MOVE: begin
                w_we = 1'b1; w_wd = r_ra;
            end
            tmhs_pkg::CMD_DN_MOVE: begin
                w_we = 1'b1; w_wd = w_right ? r_rb : r_ra;
            end
            tmhs_pkg::CMD_WR_MOVED: begin
                w_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_rea) begin
            r_ra <= r_mem[w_aa];
        end
        if (w_reb) begin
            r_rb <= r_mem[w_ab];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_op   <= '0;
        end else begin
            case (i_ctrl.cmd)
                tmhs_pkg::CMD_START: begin
                    r_op  <= i_op;
                    r_h   <= i_handle;
                    r_d   <= i_deadline;
                    r_now <= i_time_now;
                    r_fh  <= '0;
                    r_fd  <= '0;
                    r_pos <= '0;
                    if (i_op == tmhs_pkg::OP_CLEAR) begin
                        r_fill <= '0;
                    end
                end
                tmhs_pkg::CMD_INS_BEGIN: begin
                    r_hole <= w_fill;
                    r_fill <= r_fill + {{AW{1'b0}}, 1'b1};
                    r_mv_h <= r_h;
                    r_mv_d <= r_d;
                end
                tmhs_pkg::CMD_POS_INC: begin
                    r_pos <= r_pos + {{(PW-1){1'b0}}, 1'b1};
                end
                tmhs_pkg::CMD_TAKE_LAST: begin
                    if (r_op == tmhs_pkg::OP_POP) begin
                        r_fh <= r_ra[EW-1:TW];
                        r_fd <= r_ra[TW-1:0];
                    end
                    r_hole <= r_pos;
                    r_fill <= r_fill - {{AW{1'b0}}, 1'b1};
                end
                tmhs_pkg::CMD_LATCH_MV: begin
                    r_mv_h <= r_ra[EW-1:TW];
                    r_mv_d <= r_ra[TW-1:0];
                end
                tmhs_pkg::CMD_UP_MOVE: begin
                    r_hole <= w_parent;
                end
                tmhs_pkg::CMD_DN_MOVE: begin
                    r_hole <= w_ci;
                end
                default: ;
            endcase
        end
    end

    assign o_fired_handle   = r_fh;
    assign o_fired_deadline = r_fd;
    assign o_entry_count    = CW'(r_fill);

endmodule

// File: hdl/tmhs_ctrl.sv
// ----------------------------------------------------------------------------
// tmhs_ctrl
// sequencer for insert, cancel, pop and clear heap walks
// ----------------------------------------------------------------------------
module tmhs_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_out_free,
    input  tmhs_pkg::t_stat                    i_stat,
    output tmhs_pkg::t_ctrl                    o_ctrl,
    output logic                               o_idle,
    output logic                               o_done
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_UP_CHK  = 4'd2;
    localparam logic [3:0] S_UP_CMP  = 4'd3;
    localparam logic [3:0] S_SR_CHK  = 4'd4;
    localparam logic [3:0] S_SR_CMP  = 4'd5;
    localparam logic [3:0] S_POP_CHK = 4'd6;
    localparam logic [3:0] S_LAST_GO = 4'd7;
    localparam logic [3:0] S_CN_PAR  = 4'd8;
    localparam logic [3:0] S_CN_CMP  = 4'd9;
    localparam logic [3:0] S_DN_CHK  = 4'd10;
    localparam logic [3:0] S_DN_CMP  = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0] r_state, n_state;
    logic [tmhs_pkg::STATUS_W-1:0] r_status, n_status;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_ctrl.cmd    = tmhs_pkg::CMD_NONE;
        o_ctrl.status = r_status;
        o_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctrl.cmd = tmhs_pkg::CMD_START;
                    n_state = S_DISP;
                    n_status = tmhs_pkg::ST_OK;
                end
            end
            S_DISP: begin
                case (i_stat.op)
                    tmhs_pkg::OP_INSERT: begin
                        if (i_stat.full) begin
                            n_status = tmhs_pkg::ST_FULL; n_state = S_DONE;
                        end else begin
                            o_ctrl.cmd = tmhs_pkg::CMD_INS_BEGIN; n_state = S_UP_CHK;
                        end
                    end
                    tmhs_pkg::OP_CANCEL: n_state = S_SR_CHK;
                    tmhs_pkg::OP_POP: begin
                        if (i_stat.empty) begin
                            n_status = tmhs_pkg::ST_EMPTY; n_state = S_DONE;
                        end else begin
                            o_ctrl.cmd = tmhs_pkg::CMD_RD_POS; n_state = S_POP_CHK;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_UP_CHK: begin
                if (i_stat.hole_zero) begin
                    o_ctrl.cmd = tmhs_pkg::CMD_WR_MOVED; n_state = S_DONE;
                end else begin
                    o_ctrl.cmd = tmhs_pkg::CMD_RD_PARENT; n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.par_gt) begin
                    o_ctrl.cmd = tmhs_pkg::CMD_UP_MOVE; n_state = S_UP_CHK;
                end else begin
                    o_ctrl.cmd = tmhs_pkg::CMD_WR_MOVED; n_state = S_DONE;
                end
            end
            S_SR_CHK: begin
                if (i_stat.srch_end) begin
                    n_status = tmhs_pkg::ST_NOT_FOUND; n_state = S_DONE;
                end else begin
                    o_ctrl.cmd = tmhs_pkg::CMD_RD_POS; n_state = S_SR_CMP;
                end
            end
            S_SR_CMP: begin
                if (i_stat.srch_hit) begin
                    o_ctrl.cmd = tmhs_pkg::CMD_TAKE_LAST; n_state = S_LAST_GO;
                end else begin
                    o_ctrl.cmd = tmhs_pkg::CMD_POS_INC; n_state = S_SR_CHK;
                end
            end
            S_POP_CHK: begin
                if (!i_stat.root_due) begin
                    n_status = tmhs_pkg::ST_NOT_DUE; n_state = S_DONE;
                end else begin
                    o_ctrl.cmd = tmhs_pkg::CMD_TAKE_LAST; n_state = S_LAST_GO;
                end
            end
            S_LAST_GO: begin
                o_ctrl.cmd = tmhs_pkg::CMD_LATCH_MV;
                if (i_stat.hole_is_last) begin
                    n_state = S_DONE;
                end else if (i_stat.op == tmhs_pkg::OP_POP) begin
                    n_state = S_DN_CHK;
                end else begin
                    n_state = S_CN_PAR;
                end
            end
            S_CN_PAR: begin
                if (i_stat.hole_zero) begin
                    n_state = S_DN_CHK;
                end else begin
                    o_ctrl.cmd = tmhs_pkg::CMD_RD_PARENT; n_state = S_CN_CMP;
                end
            end
            S_CN_CMP: begin
                if (i_stat.par_gt) begin
                    o_ctrl.cmd = tmhs_pkg::CMD_UP_MOVE; n_state = S_UP_CHK;
                end else begin
                    n_state = S_DN_CHK;
                end
            end
            S_DN_CHK: begin
                if (i_stat.no_kid) begin
                    o_ctrl.cmd = tmhs_pkg::CMD_WR_MOVED; n_state = S_DONE;
                end else begin
                    o_ctrl.cmd = tmhs_pkg::CMD_RD_KIDS; n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_stat.dn_stop) begin
                    o_ctrl.cmd = tmhs_pkg::CMD_WR_MOVED; n_state = S_DONE;
                end else begin
                    o_ctrl.cmd = tmhs_pkg::CMD_DN_MOVE; n_state = S_DN_CHK;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= tmhs_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// File: hdl/timer_min_heap_scheduler_unit.sv
// ----------------------------------------------------------------------------
// timer_min_heap_scheduler_unit
// timer queue held as a binary min-heap in one on-chip memory
// ----------------------------------------------------------------------------
// One operation word in, one result word out, one word at a time: the input is
// ready only while the controller is idle. An insert climbs the new entry up
// the heap level by level; a due pop moves the tail entry into the root and
// sinks it level by level; a cancel runs a linear handle search over the
// entries and then walks the moved entry up or down. Clear, insert when full,
// a pop on an empty heap and a pop that is not due do no walk. Every walk
// step is a registered memory read followed by a compare and a write. A result
// still waiting in the output register holds the controller in its last state.
module timer_min_heap_scheduler_unit #(
    parameter int unsigned HEAP_DEPTH = tmhs_pkg::HEAP_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // entry_handle, deadline, time_now
    input  logic [1:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // fired_handle, fired_deadline, entry_count
    output logic [2:0]  m_axis_tuser    // status
);
    tmhs_pkg::t_ctrl w_ctrl;
    tmhs_pkg::t_stat w_stat;
    logic w_idle, w_done;
    logic [15:0] w_fh;
    logic [31:0] w_fd;
    logic [10:0] w_cnt;
    logic r_ov;
    logic [63:0] r_od;
    logic [2:0]  r_os;

    assign s_axis_tready = w_idle;

    tmhs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_axis_tvalid),
        .i_out_free (!r_ov || m_axis_tready),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl),
        .o_idle     (w_idle),
        .o_done     (w_done)
    );

    tmhs_datapath #(.HEAP_DEPTH(HEAP_DEPTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (w_ctrl),
        .i_op             (s_axis_tuser),
        .i_handle         (s_axis_tdata[15:0]),
        .i_deadline       (s_axis_tdata[47:16]),
        .i_time_now       (s_axis_tdata[79:48]),
        .o_stat           (w_stat),
        .o_fired_handle   (w_fh),
        .o_fired_deadline (w_fd),
        .o_entry_count    (w_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_done) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_od <= {5'd0, w_cnt, w_fd, w_fh};
            r_os <= w_ctrl.status;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_os;

endmodule
